// ----- rtl/pmi_pkg.sv -----
// Shared types, widths and constants of the midpoint pose integrator.
// Holds the CORDIC arctangent table and the Q2.13 heading wrap function.
// No dependencies; every other file of the block imports this package.
package pmi_pkg;

  localparam int POS_W    = 32;
  localparam int HEAD_W   = 16;
  localparam int VEL_W    = 16;
  localparam int DT_W     = 16;
  localparam int MUL1_W   = VEL_W + DT_W + 1;
  localparam int HALF_W   = 18;
  localparam int DIST_W   = 25;
  localparam int ANG_W    = 19;
  localparam int WRAP_W   = ANG_W + 2;
  localparam int Z_W      = 34;
  localparam int XY_W     = 34;
  localparam int PROD_W   = DIST_W + XY_W;
  localparam int STEP_W   = PROD_W - 30;
  localparam int SUM_W    = POS_W + 1;
  localparam int ATAN_LEN = 24;

  localparam int S_TDATA_W = 128;
  localparam int M_TDATA_W = 80;

  localparam logic signed [WRAP_W-1:0] PI_Q13     = 21'sd25736;
  localparam logic signed [WRAP_W-1:0] TWO_PI_Q13 = 21'sd51472;
  localparam logic signed [WRAP_W-1:0] FOUR_PI_Q13 = 21'sd102944;
  localparam logic signed [WRAP_W-1:0] SIX_PI_Q13 = 21'sd154416;

  localparam logic signed [HEAD_W-1:0] HEAD_MIN = -16'sd25736;
  localparam logic signed [HEAD_W-1:0] HEAD_MAX = 16'sd25735;

  localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032874;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

  typedef struct packed {
    pos_t                     px;
    pos_t                     py;
    logic signed [DIST_W-1:0] travel;
    logic signed [HEAD_W-1:0] head;
    logic                     flip;
  } pay_t;

  typedef struct packed {
    logic vld;
    vec_t vec;
    pay_t pay;
  } stage_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:       r = 34'sd843314856;
      1:       r = 34'sd497837829;
      2:       r = 34'sd263043836;
      3:       r = 34'sd133525158;
      4:       r = 34'sd67021686;
      5:       r = 34'sd33543515;
      6:       r = 34'sd16775850;
      7:       r = 34'sd8388437;
      8:       r = 34'sd4194282;
      9:       r = 34'sd2097149;
      10:      r = 34'sd1048575;
      11:      r = 34'sd524287;
      12:      r = 34'sd262143;
      13:      r = 34'sd131071;
      14:      r = 34'sd65535;
      15:      r = 34'sd32767;
      16:      r = 34'sd16383;
      17:      r = 34'sd8191;
      18:      r = 34'sd4095;
      19:      r = 34'sd2047;
      20:      r = 34'sd1023;
      21:      r = 34'sd511;
      22:      r = 34'sd255;
      23:      r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Wraps an angle into [-pi, pi); the result is correct for inputs in [-7pi, 7pi).
  function automatic logic signed [HEAD_W-1:0] wrap_q13(input logic signed [ANG_W-1:0] a);
    logic signed [WRAP_W-1:0] t;
    t = WRAP_W'(a) + PI_Q13;
    if (t >= SIX_PI_Q13) begin
      t = t - SIX_PI_Q13;
    end else if (t >= FOUR_PI_Q13) begin
      t = t - FOUR_PI_Q13;
    end else if (t >= TWO_PI_Q13) begin
      t = t - TWO_PI_Q13;
    end else if (t >= 0) begin
      t = t;
    end else if (t >= -TWO_PI_Q13) begin
      t = t + TWO_PI_Q13;
    end else if (t >= -FOUR_PI_Q13) begin
      t = t + FOUR_PI_Q13;
    end else begin
      t = t + SIX_PI_Q13;
    end
    t = t - PI_Q13;
    return t[HEAD_W-1:0];
  endfunction

endpackage

// ----- rtl/pmi_front.sv -----
// Front end of the pose integrator: velocity products, heading wrap and quadrant fold.
// Three register stages feed the first CORDIC cell. Depends on pmi_pkg.
module pmi_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic [pmi_pkg::S_TDATA_W-1:0]   data_i,
  output pmi_pkg::stage_t                 stage_o
);
  import pmi_pkg::*;

  pos_t                     px_in, py_in;
  logic signed [HEAD_W-1:0] th_in;
  logic signed [VEL_W-1:0]  v_in, w_in;
  logic signed [DT_W:0]     dt_in;
  logic signed [MUL1_W-1:0] wprod, vprod, wrnd, vrnd;

  logic                     vld1_q, vld2_q, vld3_q;
  pos_t                     px1_q, py1_q, px2_q, py2_q;
  logic signed [HEAD_W-1:0] th1_q;
  logic signed [HALF_W-1:0] half1_q;
  logic signed [DIST_W-1:0] dist1_q, dist2_q;
  logic signed [ANG_W-1:0]  mid_sum, head_sum;
  logic signed [HEAD_W-1:0] mid2_q, head2_q;
  logic signed [Z_W-1:0]    z_ext, z_fold;
  logic                     flip;
  vec_t                     vec3_q;
  pay_t                     pay3_q;

  assign px_in = data_i[31:0];
  assign py_in = data_i[63:32];
  assign th_in = data_i[79:64];
  assign v_in  = data_i[95:80];
  assign w_in  = data_i[111:96];
  assign dt_in = {1'b0, data_i[127:112]};

  assign wprod = w_in * dt_in;
  assign vprod = v_in * dt_in;
  assign wrnd  = wprod + 33'sd16384;
  assign vrnd  = vprod + 33'sd128;

  assign mid_sum  = ANG_W'(th1_q) + ANG_W'(half1_q);
  assign head_sum = ANG_W'(th1_q) + (ANG_W'(half1_q) <<< 1);

  always_comb begin
    z_ext  = Z_W'(mid2_q);
    z_ext  = z_ext <<< 17;
    z_fold = z_ext;
    flip   = 1'b0;
    if (z_ext > HALF_PI_Q30) begin
      z_fold = z_ext - PI_Q30;
      flip   = 1'b1;
    end else if (z_ext < -HALF_PI_Q30) begin
      z_fold = z_ext + PI_Q30;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px1_q   <= px_in;
      py1_q   <= py_in;
      th1_q   <= th_in;
      half1_q <= HALF_W'(wrnd >>> 15);
      dist1_q <= DIST_W'(vrnd >>> 8);

      px2_q   <= px1_q;
      py2_q   <= py1_q;
      dist2_q <= dist1_q;
      mid2_q  <= wrap_q13(mid_sum);
      head2_q <= wrap_q13(head_sum);

      vec3_q.x      <= GAIN_Q30;
      vec3_q.y      <= '0;
      vec3_q.z      <= z_fold;
      pay3_q.px     <= px2_q;
      pay3_q.py     <= py2_q;
      pay3_q.travel <= dist2_q;
      pay3_q.head   <= head2_q;
      pay3_q.flip   <= flip;
    end
  end

  assign stage_o = '{vld: vld3_q, vec: vec3_q, pay: pay3_q};

endmodule

// ----- rtl/pmi_cell.sv -----
// One CORDIC rotation cell: one micro-rotation by atan(2^-STAGE) per cycle if enabled.
// Cells are chained; each carries the pose payload to its neighbor. Depends on pmi_pkg.
module pmi_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  pmi_pkg::stage_t stage_i,
  output pmi_pkg::stage_t stage_o
);
  import pmi_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_q30(STAGE);

  logic signed [XY_W-1:0] xs, ys;
  vec_t                   vec_d, vec_q;
  pay_t                   pay_q;
  logic                   vld_q;

  assign xs = stage_i.vec.x >>> STAGE;
  assign ys = stage_i.vec.y >>> STAGE;

  always_comb begin
    if (stage_i.vec.z >= 0) begin
      vec_d.x = stage_i.vec.x - ys;
      vec_d.y = stage_i.vec.y + xs;
      vec_d.z = stage_i.vec.z - ATAN;
    end else begin
      vec_d.x = stage_i.vec.x + ys;
      vec_d.y = stage_i.vec.y - xs;
      vec_d.z = stage_i.vec.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
      pay_q <= stage_i.pay;
    end
  end

  assign stage_o = '{vld: vld_q, vec: vec_q, pay: pay_q};

endmodule

// ----- rtl/pmi_back.sv -----
// Back end of the pose integrator: scales the travel distance by cos and sin,
// rounds, adds the prior position and saturates. Two register stages. Depends on pmi_pkg.
module pmi_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  pmi_pkg::stage_t               stage_i,
  output logic                          res_vld_o,
  output logic [pmi_pkg::M_TDATA_W-1:0] res_data_o
);
  import pmi_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd536870912);

  function automatic pos_t sat_pos(input logic signed [SUM_W-1:0] v);
    pos_t r;
    if (v[SUM_W-1] != v[SUM_W-2]) begin
      r = v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  logic signed [XY_W-1:0]   cos_v, sin_v;
  logic signed [PROD_W-1:0] prodx_q, prody_q, rndx, rndy;
  logic signed [STEP_W-1:0] stepx, stepy;
  logic signed [SUM_W-1:0]  sumx, sumy;
  logic                     vld1_q, vld2_q;
  pos_t                     px1_q, py1_q, nx_q, ny_q;
  logic signed [HEAD_W-1:0] head1_q, head2_q;

  assign cos_v = stage_i.pay.flip ? -stage_i.vec.x : stage_i.vec.x;
  assign sin_v = stage_i.pay.flip ? -stage_i.vec.y : stage_i.vec.y;

  assign rndx  = prodx_q + ROUND_HALF;
  assign rndy  = prody_q + ROUND_HALF;
  assign stepx = STEP_W'(rndx >>> 30);
  assign stepy = STEP_W'(rndy >>> 30);
  assign sumx  = SUM_W'(px1_q) + SUM_W'(stepx);
  assign sumy  = SUM_W'(py1_q) + SUM_W'(stepy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= stage_i.vld;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prodx_q <= PROD_W'(stage_i.pay.travel) * PROD_W'(cos_v);
      prody_q <= PROD_W'(stage_i.pay.travel) * PROD_W'(sin_v);
      px1_q   <= stage_i.pay.px;
      py1_q   <= stage_i.pay.py;
      head1_q <= stage_i.pay.head;
      nx_q    <= sat_pos(sumx);
      ny_q    <= sat_pos(sumy);
      head2_q <= head1_q;
    end
  end

  assign res_vld_o  = vld2_q;
  assign res_data_o = {head2_q, ny_q, nx_q};

endmodule

// ----- rtl/pose_midpoint_integrator_core.sv -----
// Top level of the midpoint pose integrator: front end, CORDIC cell chain,
// back end and output register with skid stage. Depends on pmi_pkg and all pmi_* modules.
//
// Channel   Direction  Payload (low bit first)
// s_axis    in         prior_x, prior_y, prior_heading, linear_velocity,
//                      angular_velocity, time_step (128 bits)
// m_axis    out        new_x, new_y, new_heading (80 bits)
//
// One request is accepted every cycle while s_axis_tready is high; the pipeline
// is fully unrolled. The path from acceptance to m_axis_tvalid runs through the
// front stages, one register per CORDIC cell, the back stages and the output register.
// Reset clears all valid bits; no clearing pass is needed.
// A result that reaches a stalled output moves into the skid stage, after which
// the whole pipeline holds and s_axis_tready drops until the skid stage drains.
module pose_midpoint_integrator_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // prior_x, prior_y, prior_heading, linear_velocity, angular_velocity, time_step
  input  logic [pmi_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // new_x, new_y, new_heading
  output logic [pmi_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pmi_pkg::*;

  stage_t                 chain [CORDIC_STAGES+1];
  logic                   en;
  logic                   res_vld;
  logic [M_TDATA_W-1:0]   res_data;
  logic                   out_vld_q, skid_vld_q;
  logic [M_TDATA_W-1:0]   out_data_q, skid_data_q;

  assign en = !skid_vld_q;

  pmi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .stage_o (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    pmi_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  pmi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .stage_i    (chain[CORDIC_STAGES]),
    .res_vld_o  (res_vld),
    .res_data_o (res_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !m_axis_tready) begin
      if (res_vld && en) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !m_axis_tready) begin
      if (en) begin
        skid_data_q <= res_data;
      end
    end else if (skid_vld_q) begin
      out_data_q <= skid_data_q;
    end else begin
      out_data_q <= res_data;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/pmi_checker.sv -----
// Port-level checker for the midpoint pose integrator, bound to the top level.
// Counts requests in flight; checks hold, heading, count, known data. Depends on pmi_pkg.
module pmi_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [pmi_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pmi_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pmi_pkg::*;

  logic [7:0]               cnt_d, cnt_q;
  logic                     in_acc, out_acc;
  logic signed [HEAD_W-1:0] head_out;
  logic [S_TDATA_W-1:0]     in_data;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign head_out = m_axis_tdata[79:64];
  assign in_data  = s_axis_tdata;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result changed or dropped while stalled.");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (head_out >= HEAD_MIN) && (head_out <= HEAD_MAX))
    else $error("Output heading outside the wrapped range.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 8'd0)
    else $error("Result shown with no request in flight.");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> cnt_q != 8'd0)
    else $error("Input stalled while the block holds no request.");

  a_req_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid |-> !$isunknown(in_data))
    else $error("Request data unknown while valid.");

endmodule

bind pose_midpoint_integrator_core pmi_checker u_pmi_checker (.*);
